// ----- hw/rtl/bss_pkg.sv -----
// Shared types and constants for the beat step scheduler.
`default_nettype none

package bss_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int MS16_W   = 16;
    localparam int STEPS_W  = 7;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = MS16_W + STEPS_W;

    // Most steps replayed by one advance
    localparam logic [STEPS_W-1:0] MAX_CATCHUP = 7'd64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INTERVAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIBLE_WIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP     = 2'd3;

    // Configuration reset values
    localparam logic [MS16_W-1:0]  RST_STEP_PERIOD = 16'd50;
    localparam logic [STEPS_W-1:0] RST_CATCHUP     = 7'd8;
    localparam logic [MS16_W-1:0]  RST_AUDIBLE_WIN = 16'd100;
    localparam logic [MS16_W-1:0]  RST_MIN_GAP     = 16'd200;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_AT,
        ST_SET_BEAT,
        ST_MUL,
        ST_CLAMP,
        ST_REPHASE,
        ST_CHECK,
        ST_STEP,
        ST_EMIT,
        ST_ACK
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/beat_step_scheduler.sv -----
// Beat step scheduler: command sequencer, step replay loop and result register.
// One request at a time; an advance yields one result per step (at most 64 steps), and every other
// request, or an advance with no whole step, yields a single ack result.
// Reset (rst_n low, asynchronous) clears the sequencer and state, restores defaults.
`default_nettype none

module beat_step_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bss_pkg::CMD_W-1:0]     cmd,
    input  wire logic [bss_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [bss_pkg::MS16_W-1:0]    beat_interval_ms,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               stepped,
    output logic                               beat,
    output logic                               audible,
    output logic [bss_pkg::TIME_W-1:0]         step_time_ms,
    output logic                               last,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bss_pkg::MS16_W-1:0]    cfg_data
);
    import bss_pkg::*;

    state_t state_reg, state_next;

    // captured request
    logic [CMD_W-1:0]  cmd_reg,  cmd_next;
    logic [TIME_W-1:0] now_reg,  now_next;
    logic [MS16_W-1:0] ivl_reg,  ivl_next;

    // configuration
    logic [MS16_W-1:0]  period_reg;
    logic [STEPS_W-1:0] catchup_reg;
    logic [MS16_W-1:0]  window_reg;
    logic [MS16_W-1:0]  gap_reg;

    // scheduler state
    logic [MS16_W-1:0] interval_reg, interval_next;
    logic [TIME_W-1:0] lst_reg, lst_next;     // last step time
    logic [TIME_W-1:0] lbt_reg, lbt_next;     // last beat time
    logic [TIME_W-1:0] cur_reg, cur_next;     // current time

    // working registers
    logic [TIME_W-1:0] tmp_reg,  tmp_next;    // remaining time or beat anchor
    logic [PROD_W-1:0] prod_reg, prod_next;   // limit * period
    logic [TIME_W-1:0] nb_reg,   nb_next;     // next beat due time

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              stepped_reg, stepped_next;
    logic              beat_reg, beat_next;
    logic              audible_reg, audible_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              last_reg, last_next;
    logic              out_load;

    logic              in_acc;
    logic              out_free;
    logic [TIME_W-1:0] diff;
    logic              adv_ok;
    logic [STEPS_W-1:0] limit;
    logic [PROD_W:0]   thresh;
    logic              clamp;
    logic [TIME_W-1:0] period_ext;
    logic              rem_short;
    logic [TIME_W-1:0] at_diff;
    logic              at_later;
    logic [TIME_W-1:0] due_diff;
    logic [TIME_W-1:0] gap_diff;
    logic [TIME_W-1:0] aud_diff;
    logic              fire;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !out_stall;
    assign period_ext = {{(TIME_W-MS16_W){1'b0}}, period_reg};

    // advance checks
    assign diff   = now_reg - lst_reg;
    assign adv_ok = (diff != '0) && !diff[TIME_W-1] && (period_reg != '0);
    assign limit  = (catchup_reg < MAX_CATCHUP) ? catchup_reg : MAX_CATCHUP;
    assign thresh = {1'b0, prod_reg} + {{(PROD_W+1-MS16_W){1'b0}}, period_reg};
    assign clamp  = (tmp_reg >= {{(TIME_W-PROD_W-1){1'b0}}, thresh});
    assign rem_short = (tmp_reg < period_ext);

    // restart placement: earliest beat vs now
    assign at_diff  = tmp_reg - now_reg;
    assign at_later = (at_diff != '0) && !at_diff[TIME_W-1];

    // beat decision for the current step
    assign due_diff = lst_reg - nb_reg;
    assign gap_diff = lst_reg - lbt_reg;
    assign aud_diff = cur_reg - lst_reg;
    assign fire = (interval_reg != '0) && !due_diff[TIME_W-1]
                  && (gap_diff >= {{(TIME_W-MS16_W){1'b0}}, gap_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_INTERVAL:
                    begin
                        if (ivl_reg != interval_reg && interval_reg == '0 && ivl_reg != '0)
                        begin
                            state_next = ST_SET_AT;
                        end
                        else
                        begin
                            state_next = ST_ACK;
                        end
                    end
                    CMD_ADVANCE:
                    begin
                        state_next = adv_ok ? ST_MUL : ST_ACK;
                    end
                    default:
                    begin
                        state_next = ST_ACK;
                    end
                endcase
            end
            ST_SET_AT:   state_next = ST_SET_BEAT;
            ST_SET_BEAT: state_next = ST_ACK;
            ST_MUL:      state_next = ST_CLAMP;
            ST_CLAMP:    state_next = clamp ? ST_REPHASE : ST_CHECK;
            ST_REPHASE:  state_next = ST_CHECK;
            ST_CHECK:    state_next = rem_short ? ST_ACK : ST_STEP;
            ST_STEP:     state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rem_short ? ST_IDLE : ST_STEP;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and result values
    always_comb
    begin
        cmd_next      = cmd_reg;
        now_next      = now_reg;
        ivl_next      = ivl_reg;
        interval_next = interval_reg;
        lst_next      = lst_reg;
        lbt_next      = lbt_reg;
        cur_next      = cur_reg;
        tmp_next      = tmp_reg;
        prod_next     = prod_reg;
        nb_next       = nb_reg;
        out_load      = 1'b0;
        stepped_next  = stepped_reg;
        beat_next     = beat_reg;
        audible_next  = audible_reg;
        time_next     = time_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next = cmd;
                    now_next = now_ms;
                    ivl_next = beat_interval_ms;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        interval_next = '0;
                        lst_next      = now_reg;
                        lbt_next      = now_reg - {{(TIME_W-MS16_W){1'b0}}, gap_reg};
                        cur_next      = now_reg;
                    end
                    CMD_INTERVAL:
                    begin
                        interval_next = ivl_reg;
                        // earliest restart beat
                        tmp_next = lbt_reg + {{(TIME_W-MS16_W){1'b0}}, gap_reg};
                    end
                    CMD_ADVANCE:
                    begin
                        cur_next = now_reg;
                        tmp_next = diff;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SET_AT:
            begin
                tmp_next = at_later ? tmp_reg : now_reg;
            end
            ST_SET_BEAT:
            begin
                lbt_next = tmp_reg - {{(TIME_W-MS16_W){1'b0}}, ivl_reg};
            end
            ST_MUL:
            begin
                prod_next = {{(PROD_W-STEPS_W){1'b0}}, limit}
                            * {{(PROD_W-MS16_W){1'b0}}, period_reg};
            end
            ST_CLAMP:
            begin
                // skip stale time: keep only limit steps
                if (clamp)
                begin
                    lst_next = now_reg - {{(TIME_W-PROD_W){1'b0}}, prod_reg};
                    tmp_next = {{(TIME_W-PROD_W){1'b0}}, prod_reg};
                end
            end
            ST_REPHASE:
            begin
                if (interval_reg != '0)
                begin
                    lbt_next = lst_reg - {{(TIME_W-MS16_W){1'b0}}, interval_reg};
                end
            end
            ST_STEP:
            begin
                lst_next = lst_reg + period_ext;
                tmp_next = tmp_reg - period_ext;
                nb_next  = lbt_reg + {{(TIME_W-MS16_W){1'b0}}, interval_reg};
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    stepped_next = 1'b1;
                    beat_next    = fire;
                    audible_next = fire
                                   && (aud_diff <= {{(TIME_W-MS16_W){1'b0}}, window_reg});
                    time_next    = lst_reg;
                    last_next    = rem_short;
                    if (fire)
                    begin
                        lbt_next = lst_reg;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    stepped_next = 1'b0;
                    beat_next    = 1'b0;
                    audible_next = 1'b0;
                    time_next    = lst_reg;
                    last_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control, configuration and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            period_reg    <= RST_STEP_PERIOD;
            catchup_reg   <= RST_CATCHUP;
            window_reg    <= RST_AUDIBLE_WIN;
            gap_reg       <= RST_MIN_GAP;
            interval_reg  <= '0;
            lst_reg       <= '0;
            lbt_reg       <= '0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            interval_reg  <= interval_next;
            lst_reg       <= lst_next;
            lbt_reg       <= lbt_next;
            cur_reg       <= cur_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEP_PERIOD: period_reg  <= cfg_data;
                    CFG_CATCHUP:     catchup_reg <= cfg_data[STEPS_W-1:0];
                    CFG_AUDIBLE_WIN: window_reg  <= cfg_data;
                    CFG_MIN_GAP:     gap_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        ivl_reg     <= ivl_next;
        tmp_reg     <= tmp_next;
        prod_reg    <= prod_next;
        nb_reg      <= nb_next;
        stepped_reg <= stepped_next;
        beat_reg    <= beat_next;
        audible_reg <= audible_next;
        time_reg    <= time_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign stepped      = stepped_reg;
    assign beat         = beat_reg;
    assign audible      = audible_reg;
    assign step_time_ms = time_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
